// ===== rtl/rcpf_pkg.sv =====
// shared types and constants for the rotation curve planar force block
// no dependencies; imported by every rcpf module and the top level
package rcpf_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SPEED  = 1'b0,
    CFG_RADIUS = 1'b1
  } cfg_idx_t;

  localparam logic [31:0] SpeedReset  = 32'd65536;
  localparam logic [31:0] RadiusReset = 32'd65536;

  // pipeline depths
  localparam int SqrtSteps   = 32;  // one root bit per stage
  localparam int RadQuotBits = 21;  // r / r0 quotient bits below the overflow check
  localparam int SeriesTerms = 13;  // exp(-u) series terms
  localparam int PowSteps    = 31;  // conditional multiplies by exp(-1)
  localparam int QuotBits    = 33;  // force quotient bits below the overflow check

  // exp(-1) in Q0.32 and 1.0 in Q1.32
  localparam logic [30:0] ExpM1  = 31'd1580030169;
  localparam logic [32:0] OneQ32 = 33'h1_0000_0000;

  typedef struct packed {
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic               saturated;
  } out_t;

  // per-item data carried alongside the radial math
  typedef struct packed {
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic [31:0]        x_mag;
    logic [31:0]        y_mag;
    logic [63:0]        r2;
  } side_t;

endpackage

// ===== rtl/rotation_curve_planar_force.sv =====
// planar force of an exponential rotation curve, fully pipelined
// throughput: one position per clock; busy stays low, start is taken every cycle
// the depth is set by the bit-per-stage root and divider chains and the exp series
// synchronous reset clears all valid bits and loads both registers with 1.0
// results are not held: out_strobe marks a single-cycle transfer
module rotation_curve_planar_force import rcpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_strobe,
  output out_t        out_data,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] speed_r;
  logic [31:0] radius_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= SpeedReset;
      radius_r <= RadiusReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED:  speed_r  <= cfg_wdata;
        CFG_RADIUS: radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input capture, magnitudes, squares, r2
  logic        s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  in_t         s1_in_r;
  side_t       s2_side_r, s3_side_r, s4_side_r;
  logic [63:0] s3_xsq_r, s3_ysq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_in_r              <= in_data;
    s2_side_r.x_position <= s1_in_r.x_position;
    s2_side_r.y_position <= s1_in_r.y_position;
    s2_side_r.x_mag      <= s1_in_r.x_position[31] ? 32'(-s1_in_r.x_position)
                                                   : s1_in_r.x_position;
    s2_side_r.y_mag      <= s1_in_r.y_position[31] ? 32'(-s1_in_r.y_position)
                                                   : s1_in_r.y_position;
    s2_side_r.r2         <= '0;
    s3_side_r            <= s2_side_r;
    s3_xsq_r             <= {32'b0, s2_side_r.x_mag} * {32'b0, s2_side_r.x_mag};
    s3_ysq_r             <= {32'b0, s2_side_r.y_mag} * {32'b0, s2_side_r.y_mag};
    s4_side_r.x_position <= s3_side_r.x_position;
    s4_side_r.y_position <= s3_side_r.y_position;
    s4_side_r.x_mag      <= s3_side_r.x_mag;
    s4_side_r.y_mag      <= s3_side_r.y_mag;
    s4_side_r.r2         <= s3_xsq_r + s3_ysq_r;
  end

  // radius and r / r0
  logic        rt_vld;
  side_t       rt_side;
  logic [4:0]  rt_whole;
  logic [15:0] rt_frac;
  logic        rt_big;

  rcpf_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s4_vld_r),
    .in_side   (s4_side_r),
    .radius    (radius_r),
    .out_vld   (rt_vld),
    .out_side  (rt_side),
    .out_whole (rt_whole),
    .out_frac  (rt_frac),
    .out_big   (rt_big)
  );

  // exp(-r / r0)
  logic        ex_vld;
  side_t       ex_side;
  logic [32:0] ex_val;

  rcpf_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rt_vld),
    .in_side  (rt_side),
    .in_whole (rt_whole),
    .in_frac  (rt_frac),
    .in_big   (rt_big),
    .out_vld  (ex_vld),
    .out_side (ex_side),
    .out_exp  (ex_val)
  );

  // speed, speed squared, then |c| * v2 in two partial products
  logic        v_vld_r, v2_vld_r, pp_vld_r, pr_vld_r;
  side_t       v_side_r, v2_side_r, pp_side_r;
  logic [31:0] v_r;
  logic [63:0] v2_r;
  logic [64:0] v_prod;
  logic [63:0] ppx_lo_r, ppx_hi_r, ppy_lo_r, ppy_hi_r;
  logic [95:0] prx_r, pry_r;
  logic [63:0] pr_r2_r;
  logic        pr_xneg_r, pr_yneg_r, pr_origin_r;

  assign v_prod = {33'b0, speed_r} * {32'b0, 33'(OneQ32 - ex_val)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r  <= 1'b0;
      v2_vld_r <= 1'b0;
      pp_vld_r <= 1'b0;
      pr_vld_r <= 1'b0;
    end else begin
      v_vld_r  <= ex_vld;
      v2_vld_r <= v_vld_r;
      pp_vld_r <= v2_vld_r;
      pr_vld_r <= pp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    v_side_r    <= ex_side;
    v_r         <= v_prod[63:32];
    v2_side_r   <= v_side_r;
    v2_r        <= {32'b0, v_r} * {32'b0, v_r};
    pp_side_r   <= v2_side_r;
    ppx_lo_r    <= {32'b0, v2_side_r.x_mag} * {32'b0, v2_r[31:0]};
    ppx_hi_r    <= {32'b0, v2_side_r.x_mag} * {32'b0, v2_r[63:32]};
    ppy_lo_r    <= {32'b0, v2_side_r.y_mag} * {32'b0, v2_r[31:0]};
    ppy_hi_r    <= {32'b0, v2_side_r.y_mag} * {32'b0, v2_r[63:32]};
    prx_r       <= {ppx_hi_r, 32'b0} + {32'b0, ppx_lo_r};
    pry_r       <= {ppy_hi_r, 32'b0} + {32'b0, ppy_lo_r};
    pr_r2_r     <= pp_side_r.r2;
    pr_xneg_r   <= pp_side_r.x_position[31];
    pr_yneg_r   <= pp_side_r.y_position[31];
    pr_origin_r <= (pp_side_r.r2 == 64'd0);
  end

  // per-component quotient and clipping
  logic               qx_vld, qy_vld;
  logic signed [31:0] qx_val, qy_val;
  logic               qx_sat, qy_sat;

  rcpf_quot u_quot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (pr_vld_r),
    .in_prod   (prx_r),
    .in_den    (pr_r2_r),
    .in_neg    (pr_xneg_r),
    .in_origin (pr_origin_r),
    .out_vld   (qx_vld),
    .out_val   (qx_val),
    .out_sat   (qx_sat)
  );

  rcpf_quot u_quot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (pr_vld_r),
    .in_prod   (pry_r),
    .in_den    (pr_r2_r),
    .in_neg    (pr_yneg_r),
    .in_origin (pr_origin_r),
    .out_vld   (qy_vld),
    .out_val   (qy_val),
    .out_sat   (qy_sat)
  );

  // output register
  logic strobe_r;
  out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= qx_vld && qy_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r.accel_x   <= qx_val;
    out_r.accel_y   <= qy_val;
    out_r.saturated <= qx_sat || qy_sat;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

// ===== rtl/rcpf_root.sv =====
// radius stages: pipelined integer square root of r2, then r / r0 by
// pipelined restoring division; depends on rcpf_pkg
module rcpf_root import rcpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  side_t       in_side,
  input  logic [31:0] radius,
  output logic        out_vld,
  output side_t       out_side,
  output logic [4:0]  out_whole,
  output logic [15:0] out_frac,
  output logic        out_big
);

  logic        sq_vld_r  [0:SqrtSteps-1];
  side_t       sq_side_r [0:SqrtSteps-1];
  logic [33:0] sq_rem_r  [0:SqrtSteps-1];
  logic [31:0] sq_root_r [0:SqrtSteps-1];

  // square root, two radicand bits per stage
  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    logic        pv;
    side_t       ps;
    logic [33:0] prem;
    logic [31:0] proot;
    logic [35:0] acc;
    logic [35:0] trial;
    logic        take;

    if (s == 0) begin : g_first
      assign pv    = in_vld;
      assign ps    = in_side;
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_next
      assign pv    = sq_vld_r[s-1];
      assign ps    = sq_side_r[s-1];
      assign prem  = sq_rem_r[s-1];
      assign proot = sq_root_r[s-1];
    end

    assign acc   = {prem, ps.r2[2*(SqrtSteps-1-s)+1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};
    assign take  = (acc >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[s] <= 1'b0;
      end else begin
        sq_vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      sq_side_r[s] <= ps;
      sq_rem_r[s]  <= take ? 34'(acc - trial) : acc[33:0];
      sq_root_r[s] <= {proot[30:0], take};
    end
  end

  // division setup: numerator is r << 16, top bits checked for n >= 32
  logic        dp_vld_r;
  side_t       dp_side_r;
  logic [31:0] dp_rem_r;
  logic [20:0] dp_low_r;
  logic        dp_big_r;
  logic [31:0] root_w;

  assign root_w = sq_root_r[SqrtSteps-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_vld_r <= 1'b0;
    end else begin
      dp_vld_r <= sq_vld_r[SqrtSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    dp_side_r <= sq_side_r[SqrtSteps-1];
    dp_rem_r  <= {5'b0, root_w[31:5]};
    dp_low_r  <= {root_w[4:0], 16'b0};
    dp_big_r  <= ({5'b0, root_w[31:5]} >= radius);
  end

  logic        dv_vld_r  [0:RadQuotBits-1];
  side_t       dv_side_r [0:RadQuotBits-1];
  logic [31:0] dv_rem_r  [0:RadQuotBits-1];
  logic [20:0] dv_low_r  [0:RadQuotBits-1];
  logic [20:0] dv_q_r    [0:RadQuotBits-1];
  logic        dv_big_r  [0:RadQuotBits-1];

  // one quotient bit per stage
  for (genvar j = 0; j < RadQuotBits; j++) begin : g_div
    logic        pv;
    side_t       ps;
    logic [31:0] prem;
    logic [20:0] plow;
    logic [20:0] pq;
    logic        pbig;
    logic [32:0] acc;
    logic        take;

    if (j == 0) begin : g_first
      assign pv   = dp_vld_r;
      assign ps   = dp_side_r;
      assign prem = dp_rem_r;
      assign plow = dp_low_r;
      assign pq   = '0;
      assign pbig = dp_big_r;
    end else begin : g_next
      assign pv   = dv_vld_r[j-1];
      assign ps   = dv_side_r[j-1];
      assign prem = dv_rem_r[j-1];
      assign plow = dv_low_r[j-1];
      assign pq   = dv_q_r[j-1];
      assign pbig = dv_big_r[j-1];
    end

    assign acc  = {prem, plow[RadQuotBits-1-j]};
    assign take = (acc >= {1'b0, radius});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j] <= 1'b0;
      end else begin
        dv_vld_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      dv_side_r[j] <= ps;
      dv_rem_r[j]  <= take ? 32'(acc - {1'b0, radius}) : acc[31:0];
      dv_low_r[j]  <= plow;
      dv_q_r[j]    <= {pq[19:0], take};
      dv_big_r[j]  <= pbig;
    end
  end

  assign out_vld   = dv_vld_r[RadQuotBits-1];
  assign out_side  = dv_side_r[RadQuotBits-1];
  assign out_whole = dv_q_r[RadQuotBits-1][20:16];
  assign out_frac  = dv_q_r[RadQuotBits-1][15:0];
  assign out_big   = dv_big_r[RadQuotBits-1];

endmodule

// ===== rtl/rcpf_exp.sv =====
// exp(-t) stages: 13-term alternating series on the fraction, then up to
// 31 multiplies by exp(-1) for the whole part; depends on rcpf_pkg
module rcpf_exp import rcpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  side_t       in_side,
  input  logic [4:0]  in_whole,
  input  logic [15:0] in_frac,
  input  logic        in_big,
  output logic        out_vld,
  output side_t       out_side,
  output logic [32:0] out_exp
);

  localparam int SerStages = 4 * SeriesTerms;

  typedef struct packed {
    side_t       side;
    logic [4:0]  whole;
    logic        big;
    logic [31:0] u;
    logic [32:0] term;
    logic [32:0] sum;
    logic [31:0] x;
    logic [31:0] q0;
  } ser_t;

  typedef struct packed {
    side_t       side;
    logic [4:0]  whole;
    logic        big;
    logic [32:0] sum;
  } pw_t;

  ser_t ser_r     [0:SerStages-1];
  logic ser_vld_r [0:SerStages-1];
  ser_t head;

  // series starts at 1.0 with first term 1.0
  always_comb begin
    head       = '0;
    head.side  = in_side;
    head.whole = in_whole;
    head.big   = in_big;
    head.u     = {in_frac, 16'b0};
    head.term  = OneQ32;
    head.sum   = OneQ32;
  end

  // per term: multiply by u, reciprocal multiply, correct, accumulate
  for (genvar g = 0; g < SeriesTerms; g++) begin : g_term
    localparam int          Base  = 4 * g;
    localparam int          K     = g + 1;
    localparam logic [35:0] Recip = 36'((64'd1 << 35) / K);

    ser_t        a_in;
    logic        a_vld;
    logic [64:0] mul_a;
    logic [67:0] mul_b;
    logic [35:0] qk;
    logic [35:0] rem;
    ser_t        a_nxt;
    ser_t        b_nxt;
    ser_t        c_nxt;
    ser_t        d_nxt;

    if (g == 0) begin : g_head
      assign a_in  = head;
      assign a_vld = in_vld;
    end else begin : g_link
      assign a_in  = ser_r[Base-1];
      assign a_vld = ser_vld_r[Base-1];
    end

    assign mul_a = {32'b0, a_in.term} * {33'b0, a_in.u};
    assign mul_b = {36'b0, ser_r[Base].x} * {32'b0, Recip};
    assign qk    = {4'b0, ser_r[Base+1].q0} * 36'(K);
    assign rem   = {4'b0, ser_r[Base+1].x} - qk;

    always_comb begin
      a_nxt      = a_in;
      a_nxt.x    = mul_a[63:32];
      b_nxt      = ser_r[Base];
      b_nxt.q0   = mul_b[66:35];
      c_nxt      = ser_r[Base+1];
      c_nxt.term = (rem >= 36'(K)) ? {1'b0, ser_r[Base+1].q0} + 33'd1
                                    : {1'b0, ser_r[Base+1].q0};
      d_nxt      = ser_r[Base+2];
      d_nxt.sum  = (K % 2 == 1) ? ser_r[Base+2].sum - ser_r[Base+2].term
                                : ser_r[Base+2].sum + ser_r[Base+2].term;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ser_vld_r[Base]   <= 1'b0;
        ser_vld_r[Base+1] <= 1'b0;
        ser_vld_r[Base+2] <= 1'b0;
        ser_vld_r[Base+3] <= 1'b0;
      end else begin
        ser_vld_r[Base]   <= a_vld;
        ser_vld_r[Base+1] <= ser_vld_r[Base];
        ser_vld_r[Base+2] <= ser_vld_r[Base+1];
        ser_vld_r[Base+3] <= ser_vld_r[Base+2];
      end
    end

    always_ff @(posedge clk) begin
      ser_r[Base]   <= a_nxt;
      ser_r[Base+1] <= b_nxt;
      ser_r[Base+2] <= c_nxt;
      ser_r[Base+3] <= d_nxt;
    end
  end

  pw_t  pw_r     [0:PowSteps-1];
  logic pw_vld_r [0:PowSteps-1];

  // stage j multiplies by exp(-1) when j is below the whole part
  for (genvar j = 0; j < PowSteps; j++) begin : g_pow
    pw_t         p;
    logic        pv;
    logic [63:0] mul;
    pw_t         p_nxt;

    if (j == 0) begin : g_first
      assign p.side  = ser_r[SerStages-1].side;
      assign p.whole = ser_r[SerStages-1].whole;
      assign p.big   = ser_r[SerStages-1].big;
      assign p.sum   = ser_r[SerStages-1].sum;
      assign pv      = ser_vld_r[SerStages-1];
    end else begin : g_next
      assign p  = pw_r[j-1];
      assign pv = pw_vld_r[j-1];
    end

    assign mul = {31'b0, p.sum} * {33'b0, ExpM1};

    always_comb begin
      p_nxt     = p;
      p_nxt.sum = (5'(j) < p.whole) ? {1'b0, mul[63:32]} : p.sum;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_vld_r[j] <= 1'b0;
      end else begin
        pw_vld_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      pw_r[j] <= p_nxt;
    end
  end

  // whole part of 32 or more, or zero radius register, gives zero
  logic        e_vld_r;
  side_t       e_side_r;
  logic [32:0] e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= pw_vld_r[PowSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    e_side_r <= pw_r[PowSteps-1].side;
    e_r      <= pw_r[PowSteps-1].big ? 33'd0 : pw_r[PowSteps-1].sum;
  end

  assign out_vld  = e_vld_r;
  assign out_side = e_side_r;
  assign out_exp  = e_r;

endmodule

// ===== rtl/rcpf_quot.sv =====
// force quotient stages for one component: |c| * v2 / r2 by pipelined
// restoring division, then sign and clipping; depends on rcpf_pkg
module rcpf_quot import rcpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [95:0]        in_prod,
  input  logic [63:0]        in_den,
  input  logic               in_neg,
  input  logic               in_origin,
  output logic               out_vld,
  output logic signed [31:0] out_val,
  output logic               out_sat
);

  typedef struct packed {
    logic [63:0] rem;
    logic [32:0] low;
    logic [32:0] q;
    logic [63:0] den;
    logic        neg;
    logic        origin;
    logic        big;
  } qd_t;

  // setup: quotient of 2^33 or more is flagged up front
  qd_t  pre_r;
  logic pre_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pre_r.rem    <= {1'b0, in_prod[95:33]};
    pre_r.low    <= in_prod[32:0];
    pre_r.q      <= '0;
    pre_r.den    <= in_den;
    pre_r.neg    <= in_neg;
    pre_r.origin <= in_origin;
    pre_r.big    <= ({1'b0, in_prod[95:33]} >= in_den);
  end

  qd_t  qd_r     [0:QuotBits-1];
  logic qd_vld_r [0:QuotBits-1];

  // one quotient bit per stage
  for (genvar j = 0; j < QuotBits; j++) begin : g_div
    qd_t         p;
    logic        pv;
    logic [64:0] acc;
    logic        take;
    qd_t         p_nxt;

    if (j == 0) begin : g_first
      assign p  = pre_r;
      assign pv = pre_vld_r;
    end else begin : g_next
      assign p  = qd_r[j-1];
      assign pv = qd_vld_r[j-1];
    end

    assign acc  = {p.rem, p.low[QuotBits-1-j]};
    assign take = (acc >= {1'b0, p.den});

    always_comb begin
      p_nxt     = p;
      p_nxt.rem = take ? 64'(acc - {1'b0, p.den}) : acc[63:0];
      p_nxt.q   = {p.q[31:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_vld_r[j] <= 1'b0;
      end else begin
        qd_vld_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      qd_r[j] <= p_nxt;
    end
  end

  // sign flip and clipping to the signed 32-bit range; zero at the origin
  qd_t         fin;
  logic        sat_nxt;
  logic [32:0] mag_nxt;
  logic [31:0] val_nxt;
  logic        fin_vld_r;
  logic [31:0] val_r;
  logic        sat_r;

  assign fin = qd_r[QuotBits-1];

  always_comb begin
    sat_nxt = 1'b0;
    mag_nxt = '0;
    val_nxt = '0;
    if (fin.origin) begin
      sat_nxt = 1'b0;
      val_nxt = '0;
    end else if (fin.neg) begin
      sat_nxt = fin.big || (fin.q > 33'h0_7FFF_FFFF);
      val_nxt = sat_nxt ? 32'h7FFF_FFFF : fin.q[31:0];
    end else begin
      sat_nxt = fin.big || (fin.q > 33'h0_8000_0000);
      mag_nxt = sat_nxt ? 33'h0_8000_0000 : fin.q;
      val_nxt = 32'(33'd0 - mag_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= qd_vld_r[QuotBits-1];
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    sat_r <= sat_nxt;
  end

  assign out_vld = fin_vld_r;
  assign out_val = val_r;
  assign out_sat = sat_r;

endmodule
